// File: rtl/tsft_pkg.sv
// Shared types, result codes and control structs of the topic subscription table.
`default_nettype none
package tsft_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int TOPIC_W = 64;
  localparam int IP_W    = 32;
  localparam int PORT_W  = 16;
  localparam int REF_W   = 16;
  localparam int STAT_W  = 3;

  localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_DELIVER = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOMATCH = 3'd4;

  localparam logic OP_SUBSCRIBE = 1'b0;
  localparam logic OP_PUBLISH   = 1'b1;

  typedef struct packed {
    logic [TOPIC_W-1:0] topic;
    logic [IP_W-1:0]    ip;
    logic [PORT_W-1:0]  port;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic              in_ready;
    logic              load;
    logic              advance;
    logic              pend_load;
    logic              append;
    logic              emit;
    logic              emit_pend;
    logic              emit_last;
    logic [STAT_W-1:0] emit_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic is_pub;
    logic at_end;
    logic key_hit;
    logic entry_hit;
    logic pend_valid;
    logic table_full;
    logic slot_free;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/tsft_if.sv
// Request and result channel interfaces of the topic subscription table.
`default_nettype none
interface tsft_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [tsft_pkg::TOPIC_W-1:0]  topic_key;
  logic [tsft_pkg::IP_W-1:0]     src_ip;
  logic [tsft_pkg::PORT_W-1:0]   src_port;
  logic [tsft_pkg::REF_W-1:0]    message_ref;

  modport source (output valid, opcode, topic_key, src_ip, src_port, message_ref,
                  input ready);
  modport sink   (input valid, opcode, topic_key, src_ip, src_port, message_ref,
                  output ready);
endinterface

interface tsft_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tsft_pkg::STAT_W-1:0]   status;
  logic [tsft_pkg::IP_W-1:0]     dest_ip;
  logic [tsft_pkg::PORT_W-1:0]   dest_port;
  logic [tsft_pkg::REF_W-1:0]    out_message_ref;
  logic                          last;

  modport source (output valid, status, dest_ip, dest_port, out_message_ref, last,
                  input ready);
  modport sink   (input valid, status, dest_ip, dest_port, out_message_ref, last,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/tsft_datapath.sv
// Datapath: item registers, subscription memory, scan index, pending delivery, result register.
`default_nettype none
module tsft_datapath #(
  parameter int TABLE_ENTRIES = tsft_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  tsft_req_if.sink           req,
  tsft_rsp_if.source         rsp,
  input  tsft_pkg::cmd_t     cmd,
  output tsft_pkg::sts_t     sts
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  tsft_pkg::entry_t mem [TABLE_ENTRIES];

  logic                         item_op;
  logic [tsft_pkg::TOPIC_W-1:0] item_topic;
  logic [tsft_pkg::IP_W-1:0]    item_ip;
  logic [tsft_pkg::PORT_W-1:0]  item_port;
  logic [tsft_pkg::REF_W-1:0]   item_ref;

  logic [CW-1:0]                idx;
  logic [CW-1:0]                idx_next;
  logic [CW-1:0]                count;
  tsft_pkg::entry_t             rd_entry;

  logic                         pend_valid;
  logic [tsft_pkg::IP_W-1:0]    pend_ip;
  logic [tsft_pkg::PORT_W-1:0]  pend_port;

  logic                         out_valid;
  logic [tsft_pkg::STAT_W-1:0]  out_status;
  logic [tsft_pkg::IP_W-1:0]    out_ip;
  logic [tsft_pkg::PORT_W-1:0]  out_port;
  logic [tsft_pkg::REF_W-1:0]   out_ref;
  logic                         out_last;

  assign req.ready = cmd.in_ready;

  always_comb begin
    priority if (cmd.load) begin
      idx_next = '0;
    end else if (cmd.advance) begin
      idx_next = idx + CW'(1);
    end else begin
      idx_next = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else begin
      idx <= idx_next;
      if (cmd.append) begin
        count <= count + CW'(1);
      end
    end
  end

  // Registered read follows the index, so rd_entry always holds entry idx.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[count[AW-1:0]] <= '{topic: item_topic, ip: item_ip, port: item_port};
    end
    rd_entry <= mem[idx_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op    <= req.opcode;
      item_topic <= req.topic_key;
      item_ip    <= req.src_ip;
      item_port  <= req.src_port;
      item_ref   <= req.message_ref;
    end
  end

  // Hold the latest match until the scan shows whether it is the final one.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.load) begin
      pend_valid <= 1'b0;
    end else if (cmd.pend_load) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_ip   <= rd_entry.ip;
      pend_port <= rd_entry.port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.emit_status;
      out_ip     <= cmd.emit_pend ? pend_ip : '0;
      out_port   <= cmd.emit_pend ? pend_port : '0;
      out_ref    <= (item_op == tsft_pkg::OP_PUBLISH) ? item_ref : '0;
      out_last   <= cmd.emit_last;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.dest_ip         = out_ip;
  assign rsp.dest_port       = out_port;
  assign rsp.out_message_ref = out_ref;
  assign rsp.last            = out_last;

  assign sts.in_valid   = req.valid;
  assign sts.is_pub     = (item_op == tsft_pkg::OP_PUBLISH);
  assign sts.at_end     = (idx == count);
  assign sts.key_hit    = (rd_entry.topic == item_topic);
  assign sts.entry_hit  = (rd_entry.topic == item_topic) && (rd_entry.ip == item_ip)
                          && (rd_entry.port == item_port);
  assign sts.pend_valid = pend_valid;
  assign sts.table_full = (count == CW'(TABLE_ENTRIES));
  assign sts.slot_free  = !out_valid || rsp.ready;

endmodule
`default_nettype wire

// File: rtl/tsft_ctrl.sv
// Controller: sequences one item through the table scan and issues results.
`default_nettype none
module tsft_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  tsft_pkg::sts_t     sts,
  output tsft_pkg::cmd_t     cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state;
  logic state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (sts.at_end) begin
          // Final result of the item; stall until the result register frees.
          if (sts.slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
            priority if (sts.is_pub && sts.pend_valid) begin
              cmd.emit_status = tsft_pkg::ST_DELIVER;
              cmd.emit_pend   = 1'b1;
            end else if (sts.is_pub) begin
              cmd.emit_status = tsft_pkg::ST_NOMATCH;
            end else if (sts.table_full) begin
              cmd.emit_status = tsft_pkg::ST_FULL;
            end else begin
              cmd.emit_status = tsft_pkg::ST_ADDED;
              cmd.append      = 1'b1;
            end
          end
        end else if (!sts.is_pub) begin
          priority if (sts.entry_hit) begin
            if (sts.slot_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = tsft_pkg::ST_DUP;
              state_next      = S_IDLE;
            end
          end else begin
            cmd.advance = 1'b1;
          end
        end else begin
          priority if (sts.key_hit && sts.pend_valid) begin
            // Flush the earlier match as a non-final delivery.
            if (sts.slot_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_pend   = 1'b1;
              cmd.emit_status = tsft_pkg::ST_DELIVER;
              cmd.pend_load   = 1'b1;
              cmd.advance     = 1'b1;
            end
          end else if (sts.key_hit) begin
            cmd.pend_load = 1'b1;
            cmd.advance   = 1'b1;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/topic_subscription_fanout_table.sv
// Top level of the publish/subscribe topic table with delivery fan-out.
//
// Channels: req carries one subscribe (opcode 0) or publish (opcode 1) transaction;
// rsp carries result transactions, the final one of each request with last set.
// A subscribe yields one result: added, duplicate or table full. A publish yields
// one delivery per subscription whose topic matches, in table order, or one
// no-match result.
// Scan: the controller scans the table one entry per cycle through a memory
// with a registered read, unless a result waits for the output register. A
// request is accepted, then each stored entry is scanned in turn, and then the
// final result is issued; at most TABLE_ENTRIES entries are scanned. A
// duplicate subscription ends the scan at the matching entry.
// req.ready is high only while no request is being scanned, so one request is
// in flight at a time; the next is accepted while the last result still waits.
// When rsp is stalled, results wait in the output register and the scan holds
// at its next result until the register is free; nothing is dropped.
// Reset empties the table at once (the entry count is cleared); no clearing
// pass is needed.
`default_nettype none
module topic_subscription_fanout_table #(
  parameter int TABLE_ENTRIES = tsft_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tsft_req_if.sink    req,
  tsft_rsp_if.source  rsp
);

  tsft_pkg::cmd_t cmd;
  tsft_pkg::sts_t sts;

  tsft_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  tsft_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule
`default_nettype wire
